// ===== sv/acdm_pkg.sv =====
package acdm_pkg;

    localparam int SAMPLE_WIDTH   = 24;
    localparam int COEF_FRAC_BITS = 14;

    // coefficient width holds the largest coefficient plus a sign bit
    localparam int COEF_W  = COEF_FRAC_BITS + 2;
    localparam int PROD_W  = SAMPLE_WIDTH + COEF_W;
    localparam int SCALE_W = SAMPLE_WIDTH + 1;
    localparam int SUM_W   = SAMPLE_WIDTH + 3;

    localparam int COEF_SEVEN_TENTHS = ((7 << COEF_FRAC_BITS) + 5) / 10;
    localparam int COEF_ONE_HALF     = 1 << (COEF_FRAC_BITS - 1);

    localparam int STORE_DEPTH = 5;
    localparam int MAX_RESULTS = 4;

    // configuration register indexes
    localparam logic [3:0] REG_IN_COUNT  = 4'd0;
    localparam logic [3:0] REG_OUT_COUNT = 4'd1;

    // conversion modes
    localparam logic [2:0] MODE_PASS = 3'd0;
    localparam logic [2:0] MODE_UP12 = 3'd1;
    localparam logic [2:0] MODE_DN21 = 3'd2;
    localparam logic [2:0] MODE_UP24 = 3'd3;
    localparam logic [2:0] MODE_DN42 = 3'd4;
    localparam logic [2:0] MODE_DN52 = 3'd5;
    localparam logic [2:0] MODE_DN62 = 3'd6;

    typedef logic [STORE_DEPTH-1:0][SAMPLE_WIDTH-1:0] store_t;

    // results of one input sample
    typedef struct packed {
        logic [2:0]                                cnt;
        logic [2:0]                                base;
        logic [MAX_RESULTS-1:0][SAMPLE_WIDTH-1:0]  smp;
    } mix_t;

endpackage

// ===== sv/acdm_mix.sv =====
module acdm_mix
    import acdm_pkg::*;
(
    input  logic [SAMPLE_WIDTH-1:0] sample,
    input  logic [2:0]              mode,
    input  logic                    done,
    input  logic [2:0]              ch,
    input  store_t                  store,
    output mix_t                    mix
);

    // rounded product, half lsb ties toward plus infinity
    function automatic logic signed [SCALE_W-1:0] scale_coef(
        input logic signed [SAMPLE_WIDTH-1:0] x,
        input logic signed [COEF_W-1:0]       coef
    );
        logic signed [PROD_W-1:0] prod;
        prod = x * coef;
        prod = prod + PROD_W'(COEF_ONE_HALF);
        return prod[COEF_FRAC_BITS +: SCALE_W];
    endfunction

    function automatic logic [SAMPLE_WIDTH-1:0] sat(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-SAMPLE_WIDTH:0] upper;
        upper = v[SUM_W-1:SAMPLE_WIDTH-1];
        if (upper == '0 || upper == '1)
            return v[SAMPLE_WIDTH-1:0];
        else if (v[SUM_W-1])
            return {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
        else
            return {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    endfunction

    logic signed [SAMPLE_WIDTH-1:0] s, f0, f1, f2, f3, f4;
    logic signed [SCALE_W-1:0]      sev_f2, sev_s, half_f2, half_f3, half_f4, half_s;
    logic signed [SAMPLE_WIDTH:0]   pair_sum;
    logic signed [SUM_W-1:0]        sum_l, sum_r;

    assign s  = $signed(sample);
    assign f0 = $signed(store[0]);
    assign f1 = $signed(store[1]);
    assign f2 = $signed(store[2]);
    assign f3 = $signed(store[3]);
    assign f4 = $signed(store[4]);

    assign sev_f2  = scale_coef(f2, COEF_W'(COEF_SEVEN_TENTHS));
    assign sev_s   = scale_coef(s,  COEF_W'(COEF_SEVEN_TENTHS));
    assign half_f2 = scale_coef(f2, COEF_W'(COEF_ONE_HALF));
    assign half_f3 = scale_coef(f3, COEF_W'(COEF_ONE_HALF));
    assign half_f4 = scale_coef(f4, COEF_W'(COEF_ONE_HALF));
    assign half_s  = scale_coef(s,  COEF_W'(COEF_ONE_HALF));

    assign pair_sum = SCALE_W'(f0) + SCALE_W'(s);

    always_comb
    begin
        sum_l = '0;
        sum_r = '0;
        mix   = '0;
        case (mode)
            MODE_UP12:
            begin
                mix.cnt    = 3'd2;
                mix.smp[0] = s;
                mix.smp[1] = s;
            end
            MODE_DN21:
            begin
                mix.cnt    = done ? 3'd1 : 3'd0;
                mix.smp[0] = pair_sum[SAMPLE_WIDTH:1];
            end
            MODE_UP24:
            begin
                mix.cnt    = done ? 3'd4 : 3'd0;
                mix.smp[0] = f0;
                mix.smp[1] = s;
                mix.smp[2] = f0;
                mix.smp[3] = s;
            end
            MODE_DN42:
            begin
                sum_l      = SUM_W'(f0) + SUM_W'(sev_f2);
                sum_r      = SUM_W'(f1) + SUM_W'(sev_s);
                mix.cnt    = done ? 3'd2 : 3'd0;
                mix.smp[0] = sat(sum_l);
                mix.smp[1] = sat(sum_r);
            end
            MODE_DN52:
            begin
                sum_l      = SUM_W'(f0) + SUM_W'(half_f2) + SUM_W'(f3);
                sum_r      = SUM_W'(f1) + SUM_W'(half_f2) + SUM_W'(s);
                mix.cnt    = done ? 3'd2 : 3'd0;
                mix.smp[0] = sat(sum_l);
                mix.smp[1] = sat(sum_r);
            end
            MODE_DN62:
            begin
                sum_l      = SUM_W'(f0) + SUM_W'(half_f2) + SUM_W'(half_f3)
                             + SUM_W'(half_f4);
                sum_r      = SUM_W'(f1) + SUM_W'(half_f2) + SUM_W'(half_f3)
                             + SUM_W'(half_s);
                mix.cnt    = done ? 3'd2 : 3'd0;
                mix.smp[0] = sat(sum_l);
                mix.smp[1] = sat(sum_r);
            end
            default:
            begin
                mix.cnt    = 3'd1;
                mix.base   = ch;
                mix.smp[0] = s;
            end
        endcase
    end

endmodule

// ===== sv/audio_channel_downmix_upmix_top.sv =====
// audio channel layout converter (downmix / upmix)
// input: s_tvalid/s_tready/s_tdata, one interleaved q1.23 sample per transaction
// output: m_tvalid/m_tready/m_tdata/m_tlast, one converted sample per transaction;
//   m_tlast marks the last output caused by one input sample
// config: cfg_valid/cfg_ready/cfg_index/cfg_data, index 0 = input channel count,
//   index 1 = output channel count; a write to either register restarts the frame.
//   write only while idle; cfg_ready is always high
// except in pass-through and 1->2, frames are collected internally; the sample that
// completes a frame releases that frame's outputs, earlier ones produce nothing
// a taken sample sits in the input register, its results then in the result register
// throughput: one input per cycle while m_tready is high, when it yields at most one
//   output; an input that yields more than one output holds the result register until
//   the last is sent, since the result register sends one output per cycle while
//   m_tready is high (1->2 and 2->4 give two outputs per input on average)
// reset: counts return to 2 and 2, frame position to 0, both stages empty
// stall: while m_tready is low the result register holds; the input register
//   still takes samples until it holds one that has outputs, then s_tready
//   drops until the result register frees up
module audio_channel_downmix_upmix_top
    import acdm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,     // [23:0] sample_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,     // [23:0] sample_out, [26:24] out_channel, zero above
    output logic        m_tlast,     // run_end
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    // configuration and frame state
    logic [3:0] in_count_reg, out_count_reg;
    logic [2:0] fpos_reg, fpos_next;
    store_t     frame_store_reg;

    // input stage
    logic                    a_valid_reg;
    logic [SAMPLE_WIDTH-1:0] a_sample_reg;
    logic [2:0]              a_mode_reg;
    logic                    a_done_reg;
    logic [2:0]              a_ch_reg;

    // result stage
    logic [2:0]                               b_cnt_reg;
    logic [1:0]                               b_idx_reg;
    logic [2:0]                               b_base_reg;
    logic [MAX_RESULTS-1:0][SAMPLE_WIDTH-1:0] b_smp_reg;

    logic       in_take, out_take, b_last, b_free, a_adv, b_load;
    logic [2:0] mode;
    logic       collect_mode;
    logic [3:0] n_eff;
    logic [2:0] pos;
    logic       wrap;
    mix_t       mix;

    // mode from the channel count pair
    always_comb
    begin
        mode         = MODE_PASS;
        collect_mode = 1'b0;
        n_eff        = in_count_reg;
        if (in_count_reg == 4'd1 && out_count_reg == 4'd2)
            mode = MODE_UP12;
        else if (in_count_reg == 4'd2 && out_count_reg == 4'd1)
            mode = MODE_DN21;
        else if (in_count_reg == 4'd2 && out_count_reg == 4'd4)
            mode = MODE_UP24;
        else if (in_count_reg == 4'd4 && out_count_reg == 4'd2)
            mode = MODE_DN42;
        else if (in_count_reg == 4'd5 && out_count_reg == 4'd2)
            mode = MODE_DN52;
        else if (in_count_reg == 4'd6 && out_count_reg == 4'd2)
            mode = MODE_DN62;
        collect_mode = (mode != MODE_PASS) && (mode != MODE_UP12);
        // pass-through frame length clamps to 1..8
        if (in_count_reg == 4'd0)
            n_eff = 4'd1;
        else if (in_count_reg > 4'd8)
            n_eff = 4'd8;
    end

    // frame position bookkeeping
    always_comb
    begin
        pos  = ({1'b0, fpos_reg} >= n_eff) ? 3'd0 : fpos_reg;
        wrap = ({1'b0, pos} + 4'd1) >= n_eff;
        if (mode == MODE_UP12 || wrap)
            fpos_next = 3'd0;
        else
            fpos_next = pos + 3'd1;
    end

    // handshakes
    assign b_last   = ({1'b0, b_idx_reg} + 3'd1) == b_cnt_reg;
    assign out_take = m_tvalid && m_tready;
    assign b_free   = (b_cnt_reg == 3'd0) || (out_take && b_last);
    assign a_adv    = a_valid_reg && (b_free || mix.cnt == 3'd0);
    assign b_load   = a_valid_reg && b_free && (mix.cnt != 3'd0);
    assign s_tready = !a_valid_reg || a_adv;
    assign in_take  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    acdm_mix u_mix (
        .sample (a_sample_reg),
        .mode   (a_mode_reg),
        .done   (a_done_reg),
        .ch     (a_ch_reg),
        .store  (frame_store_reg),
        .mix    (mix)
    );

    // configuration registers and frame position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_count_reg  <= 4'd2;
            out_count_reg <= 4'd2;
            fpos_reg      <= 3'd0;
        end
        else if (cfg_valid && cfg_ready &&
                 (cfg_index == REG_IN_COUNT || cfg_index == REG_OUT_COUNT))
        begin
            if (cfg_index == REG_IN_COUNT)
                in_count_reg <= cfg_data[3:0];
            else
                out_count_reg <= cfg_data[3:0];
            fpos_reg <= 3'd0;
        end
        else if (in_take)
        begin
            fpos_reg <= fpos_next;
        end
    end

    // earlier channels of the current frame
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            if (in_take && collect_mode && !wrap && pos == 3'(i))
                frame_store_reg[i] <= s_tdata;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (in_take)
            a_valid_reg <= 1'b1;
        else if (a_adv)
            a_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            a_sample_reg <= s_tdata;
            a_mode_reg   <= mode;
            a_done_reg   <= wrap;
            a_ch_reg     <= pos;
        end
    end

    // result register, sends one output per cycle while m_tready is high
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_cnt_reg <= 3'd0;
            b_idx_reg <= 2'd0;
        end
        else if (b_load)
        begin
            b_cnt_reg <= mix.cnt;
            b_idx_reg <= 2'd0;
        end
        else if (out_take && b_last)
        begin
            b_cnt_reg <= 3'd0;
        end
        else if (out_take)
        begin
            b_idx_reg <= b_idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_load)
        begin
            b_smp_reg  <= mix.smp;
            b_base_reg <= mix.base;
        end
    end

    assign m_tvalid = b_cnt_reg != 3'd0;
    assign m_tlast  = b_last;
    assign m_tdata  = {5'd0, b_base_reg + {1'b0, b_idx_reg}, b_smp_reg[b_idx_reg]};

endmodule

// ===== sv/acdm_checker.sv =====
module acdm_checker
    import acdm_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast
);

    // reset empties the result register
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("output valid during reset");

    // outputs of one input sample follow without a gap
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("run ended without tlast");

    // channel index steps by one within a run
    a_channel_step: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=>
        m_tdata[26:24] == $past(m_tdata[26:24]) + 3'd1)
        else $error("channel index out of sequence");

    // stalled transaction holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output changed");

endmodule

bind audio_channel_downmix_upmix_top acdm_checker u_acdm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
